// ===== src/chm_pkg.sv =====
`timescale 1ns / 1ps
package chm_pkg;
    localparam int HASH_CHAINS   = 1024;
    localparam int TABLE_ENTRIES = 4096;
    localparam int VALUE_CAP     = 30;
    localparam int CHAIN_W = $clog2(HASH_CHAINS);
    localparam int ENTRY_W = $clog2(TABLE_ENTRIES);
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W   = 59;
    localparam int CODE_W  = 5;
    localparam logic [CODE_W-1:0] LOONY_CODE = 5'd31;
    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
        logic [CHAIN_W-1:0] chain;
    } req_t;

    function automatic logic [63:0] mix_half(input logic [63:0] h, input logic [31:0] half);
        logic [63:0] t;
        t = h + {32'd0, half};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [63:0] mix_final(input logic [63:0] h);
        logic [63:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction
endpackage

// ===== src/chm_front.sv =====
`timescale 1ns / 1ps
// Hashes over three registered steps, one half or the final mix per step.
module chm_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           opcode,
    input  logic [58:0]    key,
    input  logic [4:0]     value,
    input  logic           loony,
    output logic           q_valid,
    input  logic           q_ready,
    output chm_pkg::req_t  q_req
);
    import chm_pkg::*;

    logic [1:0]        step_reg, step_next;
    logic [63:0]       h_reg, h_next;
    logic [63:0]       word_reg, word_next;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CODE_W-1:0] code_reg, code_in;
    logic [1:0]        qn_reg, qn_next;
    req_t              q_mem [2];
    logic              rd_reg, wr_reg;
    logic [63:0]       hf;

    localparam logic [1:0] S_IDLE = 2'd0, S_HI = 2'd1, S_FIN = 2'd2;

    assign in_ready = (step_reg == S_IDLE);
    assign code_in  = loony ? LOONY_CODE :
                      ((value > CODE_W'(VALUE_CAP)) ? CODE_W'(VALUE_CAP) : value);
    assign hf = mix_final(h_reg);

    always_comb
    begin
        step_next = step_reg;
        h_next    = h_reg;
        word_next = word_reg;
        unique case (step_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next = {key, 5'd0};
                    h_next    = mix_half(64'd0, word_next[31:0]);
                    step_next = S_HI;
                end
            end
            S_HI:
            begin
                h_next    = mix_half(h_reg, word_reg[63:32]);
                step_next = S_FIN;
            end
            S_FIN:
            begin
                if (qn_reg != 2'd2)
                    step_next = S_IDLE;
            end
            default: step_next = S_IDLE;
        endcase
    end

    logic push, pop;
    assign push = (step_reg == S_FIN) && (qn_reg != 2'd2);
    assign pop  = q_valid && q_ready;
    assign q_valid = (qn_reg != 2'd0);
    assign q_req   = q_mem[rd_reg];
    assign qn_next = qn_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
            qn_reg   <= 2'd0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            qn_reg   <= qn_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        word_reg <= word_next;
        if (in_valid && in_ready)
        begin
            op_reg   <= opcode;
            key_reg  <= key;
            code_reg <= code_in;
        end
        if (push)
            q_mem[wr_reg] <= '{op: op_reg, key: key_reg, code: code_reg,
                               chain: hf[CHAIN_W-1:0]};
    end
endmodule

// ===== src/chm_back.sv =====
`timescale 1ns / 1ps
// Executes queued transactions against the head and entry memories.
module chm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  chm_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          found,
    output logic [4:0]    result_value,
    output logic          result_loony,
    output logic          table_full
);
    import chm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_HEAD = 3'd2,
                           S_HWAIT = 3'd3, S_ENT = 3'd4, S_EWAIT = 3'd5,
                           S_OUT = 3'd6;

    // head word: {valid, index}
    logic [ENTRY_W:0]   heads [HASH_CHAINS];
    logic [KEY_W-1:0]   ekeys [TABLE_ENTRIES];
    logic [CODE_W-1:0]  evals [TABLE_ENTRIES];
    logic [ENTRY_W:0]   elinks[TABLE_ENTRIES];

    logic [2:0]         st_reg;
    logic [CHAIN_W:0]   clr_reg;
    logic [COUNT_W-1:0] cnt_reg, steps_reg;
    req_t               req_reg;
    logic [ENTRY_W:0]   head_rd, link_rd;
    logic [KEY_W-1:0]   key_rd;
    logic [CODE_W-1:0]  val_rd;
    logic [ENTRY_W:0]   at_reg;
    logic               f_reg, full_reg;
    logic [CODE_W-1:0]  v_reg;

    assign q_ready      = (st_reg == S_IDLE);
    assign out_valid    = (st_reg == S_OUT);
    assign found        = f_reg;
    assign result_value = v_reg;
    assign result_loony = f_reg && (v_reg == LOONY_CODE);
    assign table_full   = full_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLR)
            heads[clr_reg[CHAIN_W-1:0]] <= '0;
        else if (st_reg == S_HWAIT && req_reg.op == OP_INSERT
                 && cnt_reg < COUNT_W'(TABLE_ENTRIES))
            heads[req_reg.chain] <= {1'b1, cnt_reg[ENTRY_W-1:0]};
        head_rd <= heads[req_reg.chain];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_HWAIT && req_reg.op == OP_INSERT
            && cnt_reg < COUNT_W'(TABLE_ENTRIES))
        begin
            ekeys[cnt_reg[ENTRY_W-1:0]]  <= req_reg.key;
            evals[cnt_reg[ENTRY_W-1:0]]  <= req_reg.code;
            elinks[cnt_reg[ENTRY_W-1:0]] <= head_rd;
        end
        key_rd  <= ekeys[at_reg[ENTRY_W-1:0]];
        val_rd  <= evals[at_reg[ENTRY_W-1:0]];
        link_rd <= elinks[at_reg[ENTRY_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLR;
            clr_reg  <= '0;
            cnt_reg  <= '0;
            f_reg    <= 1'b0;
            full_reg <= 1'b0;
            v_reg    <= '0;
        end
        else
        begin
            unique case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (CHAIN_W+1)'(HASH_CHAINS - 1))
                        st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg  <= q_req;
                        f_reg    <= 1'b0;
                        full_reg <= 1'b0;
                        v_reg    <= '0;
                        st_reg   <= S_HEAD;
                    end
                end
                S_HEAD: st_reg <= S_HWAIT;  // head read in flight
                S_HWAIT:
                begin
                    steps_reg <= '0;
                    at_reg    <= head_rd;
                    if (req_reg.op == OP_INSERT)
                    begin
                        if (cnt_reg < COUNT_W'(TABLE_ENTRIES))
                            cnt_reg <= cnt_reg + 1'b1;
                        else
                            full_reg <= 1'b1;
                        st_reg <= S_OUT;
                    end
                    else if (head_rd[ENTRY_W] && cnt_reg != '0)
                        st_reg <= S_ENT;
                    else
                        st_reg <= S_OUT;
                end
                S_ENT: st_reg <= S_EWAIT;   // entry read in flight
                S_EWAIT:
                begin
                    if (key_rd == req_reg.key)
                    begin
                        f_reg  <= 1'b1;
                        v_reg  <= val_rd;
                        st_reg <= S_OUT;
                    end
                    else if (link_rd[ENTRY_W] && (steps_reg + 1'b1) < cnt_reg)
                    begin
                        steps_reg <= steps_reg + 1'b1;
                        at_reg    <= link_rd;
                        st_reg    <= S_ENT;
                    end
                    else
                        st_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/chained_hash_memo_table.sv =====
`timescale 1ns / 1ps
// channel | signals                                  | direction
// in      | in_valid/in_ready, opcode key value loony | to block
// out     | out_valid/out_ready, found result_value   | from block
//         | result_loony table_full                   |
// Front hashes the low key half, high half, then final mix; back reads the head,
// then one chain entry at a time. A 2-deep queue parts front and back.
// After reset the back clears the 1024 chain heads, one per cycle, before work.
// A stalled output holds the back; the front keeps hashing until the queue fills.
module chained_hash_memo_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [58:0] key,
    input  logic [4:0]  value,
    input  logic        loony,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [4:0]  result_value,
    output logic        result_loony,
    output logic        table_full
);
    import chm_pkg::*;

    logic q_valid, q_ready;
    req_t q_req;

    chm_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .opcode, .key, .value, .loony,
        .q_valid, .q_ready, .q_req
    );

    chm_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_req, .out_valid, .out_ready,
        .found, .result_value, .result_loony, .table_full
    );
endmodule
